/* hw/rtl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes for the sorted list engine
// Operation and status codes, fixed field widths, cell control group.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int OP_W       = 2;
  localparam int IN_VALUE_W = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

/* hw/rtl/sle_req_if.sv */
// ----------------------------------------------------------------------------
// sle_req_if: request channel
// Valid/ready channel carrying one operation and its operand.
// ----------------------------------------------------------------------------
interface sle_req_if import sle_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [IN_VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

/* hw/rtl/sle_rsp_if.sv */
// ----------------------------------------------------------------------------
// sle_rsp_if: response channel
// Valid/ready channel carrying a status and the entry count.
// ----------------------------------------------------------------------------
interface sle_rsp_if import sle_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

/* hw/rtl/sle_cell.sv */
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted store
// Holds one entry, registers its compare against the key, and shifts
// toward or away from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic                   occ,
  input  logic                   left_lt,
  input  logic [VALUE_WIDTH-1:0] left_data,
  input  logic [VALUE_WIDTH-1:0] right_data,
  output logic [VALUE_WIDTH-1:0] data,
  output logic                   lt,
  output logic                   eq
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occ && (data < key);
      eq <= occ && (data == key);
    end
    if (ctl.ins && !lt) begin
      data <= left_lt ? key : left_data;
    end else if (ctl.rem && !lt) begin
      data <= right_data;
    end
  end

endmodule

/* hw/rtl/sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine: sorted multiset store
// Ascending store of unsigned values in a row of cells; insert, remove
// one copy, search. One response per request.
//
//   port  dir  payload          notes
//   req   in   op, value        insert / remove / search
//   rsp   out  status, count    held until taken
//
// Each request passes through accept, per-cell compare, then shift/update.
// The compare is registered in every cell before the shift step.
// A new request is taken while a response waits; its update step stalls
// until the response register is free.
// Synchronous reset empties the store; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_engine import sle_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;

  logic [1:0]             phase;
  logic [OP_W-1:0]        op;
  logic [VALUE_WIDTH-1:0] key;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [STATUS_W-1:0]    status_next;

  logic [VALUE_WIDTH-1:0] data [CAPACITY];
  logic [CAPACITY-1:0]    lt_v;
  logic [CAPACITY-1:0]    eq_v;
  logic                   found;
  logic                   full;
  logic                   advance;
  cell_ctl_t              ctl;

  logic [VALUE_WIDTH+IN_VALUE_W-1:0] value_ext;
  logic [CNT_W+COUNT_W-1:0]          count_ext;

  assign value_ext = {{VALUE_WIDTH{1'b0}}, req.value};
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  assign found   = |eq_v;
  assign full    = (count == CNT_W'(CAPACITY));
  assign advance = !rsp.valid || rsp.ready;

  assign req.ready = (phase == PH_IDLE);

  assign ctl.cmp = (phase == PH_CMP);
  assign ctl.ins = (phase == PH_UPD) && advance && (op == OP_INSERT) && !full;
  assign ctl.rem = (phase == PH_UPD) && advance && (op == OP_REMOVE) && found;

  always_comb begin
    count_next  = count;
    status_next = ST_MISSING;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          count_next  = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          status_next = ST_OK;
          count_next  = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        if (found) begin
          status_next = ST_OK;
        end
      end
      default: begin
        status_next = ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (req.valid) begin
            phase <= PH_CMP;
          end
        end
        PH_CMP: begin
          phase <= PH_UPD;
        end
        PH_UPD: begin
          if (advance) begin
            count      <= count_next;
            rsp.status <= status_next;
            rsp.count  <= count_ext[COUNT_W-1:0];
            phase      <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
      if ((phase == PH_UPD) && advance) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= req.op;
      key <= value_ext[VALUE_WIDTH-1:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_lt;
    logic [VALUE_WIDTH-1:0] left_data;
    logic [VALUE_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_data = key;
    end else begin : g_mid
      assign left_lt   = lt_v[i-1];
      assign left_data = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = data[i];
    end else begin : g_inner
      assign right_data = data[i+1];
    end

    sle_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key),
      .occ        (CNT_W'(i) < count),
      .left_lt    (left_lt),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (data[i]),
      .lt         (lt_v[i]),
      .eq         (eq_v[i])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_UPD) |=> $stable(count))
    else $error("entry count changed outside update step");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not add an entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> full)
    else $error("full status with room left");
`endif

endmodule

/* verif/sorted_list_engine_checker.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine_checker: response checker for the sorted list engine
// Watches both channels, keeps its own sorted store updated on each
// accepted request, and compares each accepted response in order.
// ----------------------------------------------------------------------------
module sorted_list_engine_checker import sle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sle_req_if          req,
  sle_rsp_if          rsp,
  output int unsigned failures,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned full_rejects
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  logic [IN_VALUE_W-1:0] sorted_vals [CAPACITY];
  int                    held;
  outcome_t              outcomes_due [$];
  int unsigned           fail_n;
  int unsigned           checked_n;
  int unsigned           full_n;

  function automatic outcome_t apply_request(logic [OP_W-1:0] op, logic [IN_VALUE_W-1:0] v);
    outcome_t o;
    int       pos;
    int       i;
    o.status = ST_MISSING;
    pos = 0;
    while (pos < held && sorted_vals[pos] < v) pos++;
    case (op)
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (i = held; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = v;
          held++;
          o.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (pos < held && sorted_vals[pos] == v) begin
          for (i = pos; i < held - 1; i++) sorted_vals[i] = sorted_vals[i+1];
          held--;
          o.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        if (pos < held && sorted_vals[pos] == v) o.status = ST_OK;
      end
      default: begin
      end
    endcase
    o.count = held[COUNT_W-1:0];
    return o;
  endfunction

  initial begin
    held = 0;
    fail_n = 0;
    checked_n = 0;
    full_n = 0;
  end

  always @(posedge clk) begin
    outcome_t due;
    if (rst) begin
      held = 0;
      outcomes_due.delete();
    end else begin
      if (req.valid && req.ready) begin
        due = apply_request(req.op, req.value);
        if (due.status == ST_FULL) full_n++;
        outcomes_due.push_back(due);
      end
      if (rsp.valid && rsp.ready) begin
        checked_n++;
        if (outcomes_due.size() == 0) begin
          $error("unexpected item: status %0d count %0d", rsp.status, rsp.count);
          fail_n++;
        end else begin
          due = outcomes_due.pop_front();
          if (rsp.status !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d", due.status, rsp.status);
            fail_n++;
          end
          if (rsp.count !== due.count) begin
            $error("count mismatch: expected %0d, actual %0d", due.count, rsp.count);
            fail_n++;
          end
        end
      end
    end
    failures     <= fail_n;
    pending      <= outcomes_due.size();
    checked      <= checked_n;
    full_rejects <= full_n;
  end

endmodule

/* verif/sorted_list_engine_test.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine_test: testbench top for the sorted list engine
// Directed corner items, then random fill/drain bursts under three idle
// patterns; a checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module sorted_list_engine_test;
  import sle_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int              LIMIT_CYCLES = 100000;
  localparam int              DRAIN_CYCLES = 12;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sle_req_if req ();
  sle_rsp_if rsp ();

  int unsigned failures;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_rejects;

  int          send_idle_pct;
  int          stall_pct;
  int unsigned cycles;
  int unsigned n_insert, n_remove, n_search, n_unused;
  logic [IN_VALUE_W-1:0] recent [$];
  mix_t        mix;
  int          burst_left;

  sorted_list_engine u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sorted_list_engine_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .failures     (failures),
    .pending      (pending),
    .checked      (checked),
    .full_rejects (full_rejects)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
    case (op)
      OP_INSERT: begin
        n_insert++;
        recent.push_back(value);
        if (recent.size() > 24) void'(recent.pop_front());
      end
      OP_REMOVE: n_remove++;
      OP_SEARCH: n_search++;
      default:   n_unused++;
    endcase
  endtask

  function automatic logic [IN_VALUE_W-1:0] pick_value(int recent_pct);
    int r;
    r = $urandom_range(99);
    if (r < recent_pct && recent.size() != 0) return recent[$urandom_range(recent.size() - 1)];
    if (r < recent_pct + 20) return IN_VALUE_W'($urandom_range(15));
    if (r < recent_pct + 30) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return IN_VALUE_W'(1);
        default: return {1'b1, {(IN_VALUE_W-1){1'b0}}};
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_random();
    int              r;
    logic [OP_W-1:0] op;
    if (burst_left == 0) begin
      mix = mix_t'($urandom_range(2));
      burst_left = $urandom_range(45, 15);
    end
    burst_left--;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  op = (r < 70) ? OP_INSERT : (r < 85) ? OP_REMOVE : (r < 97) ? OP_SEARCH : OP_UNUSED;
      MIX_DRAIN: op = (r < 15) ? OP_INSERT : (r < 80) ? OP_REMOVE : (r < 97) ? OP_SEARCH : OP_UNUSED;
      default:   op = (r < 40) ? OP_INSERT : (r < 72) ? OP_REMOVE : (r < 97) ? OP_SEARCH : OP_UNUSED;
    endcase
    send_item(op, pick_value(op == OP_INSERT ? 25 : 65));
  endtask

  initial begin
    int i;
    req.valid = 1'b0;
    req.op    = OP_SEARCH;
    req.value = '0;
    burst_left = 0;
    mix = MIX_EVEN;
    send_idle_pct = 25;
    stall_pct = 49;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty store
    send_item(OP_SEARCH, '0);
    send_item(OP_REMOVE, 32'd7);
    send_item(OP_UNUSED, '0);
    // extremes and duplicates
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_SEARCH, '1);
    send_item(OP_SEARCH, 32'd5);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, 32'd5);
    // fill to capacity, then overflow
    for (i = 0; i < CAPACITY_DEF - 2; i++) begin
      send_item(OP_INSERT, (i % 2) ? (32'h5555_5555 ^ i) : (32'hAAAA_AAAA - i));
    end
    send_item(OP_INSERT, 32'h1234_5678);
    send_item(OP_UNUSED, '1);

    for (i = 0; i < 120; i++) send_random();
    send_idle_pct = 49;
    stall_pct <= 25;
    for (i = 0; i < 140; i++) send_random();
    send_idle_pct = 0;
    stall_pct <= 0;
    for (i = 0; i < 140; i++) send_random();

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests (insert %0d, remove %0d, search %0d, unused op %0d)",
             n_insert + n_remove + n_search + n_unused, n_insert, n_remove, n_search, n_unused);
    $display("summary: %0d responses checked, %0d inserts rejected on a full store",
             checked, full_rejects);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
